@@ hw/rtl/two_sensor_delta_running_stats_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the two-sensor running statistics block
// Clocked implication checks, reset gated, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef TWO_SENSOR_DELTA_RUNNING_STATS_ASSERT_SVH
`define TWO_SENSOR_DELTA_RUNNING_STATS_ASSERT_SVH

// same-cycle implication
`define TSDRS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSDRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tsdrs_pkg.sv @@
// ----------------------------------------------------------------------------
// tsdrs_pkg
// Shared types and constants of the two-sensor running statistics block.
// ----------------------------------------------------------------------------
package tsdrs_pkg;

    // field widths fixed by the item format
    localparam int TEMP_W       = 12;
    localparam int VALUE_W      = TEMP_W + 1;
    localparam int STATUS_W     = 2;
    localparam int CHANNEL_W    = 2;
    localparam int NUM_CHANNELS = 3;

    // defaults of the top-level parameters
    localparam int MEAN_FRAC_BITS_DEF = 8;
    localparam int COUNT_WIDTH_DEF    = 32;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_UPDATED = 2'd0,
        ST_FAULT   = 2'd1,
        ST_CLEARED = 2'd2
    } t_status;

    // channel codes
    typedef enum logic [CHANNEL_W-1:0] {
        CH_FIRST  = 2'd0,
        CH_SECOND = 2'd1,
        CH_DELTA  = 2'd2
    } t_channel;

    // commands from controller to datapath
    typedef struct packed {
        logic     capture;
        logic     clear;
        logic     fault_inc;
        logic     div_start;
        logic     update;
        logic     count_inc;
        logic     load_out;
        t_channel ch;
        t_status  status;
        logic     last;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic is_clear;
        logic is_ok;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

@@ hw/rtl/tsdrs_if.sv @@
// ----------------------------------------------------------------------------
// tsdrs_if
// Valid/ready channels carrying sample items in and statistics items out.
// ----------------------------------------------------------------------------

// input channel: one sample event or clear command per item
interface tsdrs_in_if import tsdrs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic                     sample_ok;
    logic signed [TEMP_W-1:0] first_temp;
    logic signed [TEMP_W-1:0] second_temp;

    modport source (output valid, cmd, sample_ok, first_temp, second_temp, input ready);
    modport sink   (input valid, cmd, sample_ok, first_temp, second_temp, output ready);
endinterface

// output channel: statistics of one channel per item
interface tsdrs_out_if import tsdrs_pkg::*; #(
    parameter int MEAN_FRAC_BITS = MEAN_FRAC_BITS_DEF,
    parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF
) ();
    localparam int MEAN_W = VALUE_W + MEAN_FRAC_BITS;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [CHANNEL_W-1:0]      channel;
    logic signed [VALUE_W-1:0] latest_value;
    logic signed [VALUE_W-1:0] minimum_value;
    logic signed [VALUE_W-1:0] maximum_value;
    logic signed [MEAN_W-1:0]  mean_value;
    logic [COUNT_WIDTH-1:0]    reading_total;
    logic [COUNT_WIDTH-1:0]    fault_total;
    logic                      last;

    modport source (output valid, status, channel, latest_value, minimum_value,
                    maximum_value, mean_value, reading_total, fault_total, last,
                    input ready);
    modport sink   (input valid, status, channel, latest_value, minimum_value,
                    maximum_value, mean_value, reading_total, fault_total, last,
                    output ready);
endinterface

@@ hw/rtl/two_sensor_delta_running_stats.sv @@
// ----------------------------------------------------------------------------
// two_sensor_delta_running_stats
// Running latest/min/max/mean for two temperature sensors and their
// absolute difference. Each input item is a sample pair or a clear command.
// A good sample gives three result items (first, second, delta channel, last
// set on the delta item); a failed sample or a clear gives one item on the
// first channel. The mean carries MEAN_FRAC_BITS fraction bits and is
// updated by mean += (v*2^MEAN_FRAC_BITS - mean)/(n+1), truncated toward
// zero, through one shared bit-serial divider. One item is worked on at a
// time: the divider gives one quotient bit per cycle and runs in turn for
// each of the three channels of a good sample; fault and clear items skip
// the divider. Result items wait in an output register, so the next input
// item is accepted while the last result is still unclaimed.
// ----------------------------------------------------------------------------
module two_sensor_delta_running_stats import tsdrs_pkg::*; #(
    parameter int MEAN_FRAC_BITS = MEAN_FRAC_BITS_DEF,
    parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tsdrs_in_if.sink     i_in,
    tsdrs_out_if.source  o_out
);

    t_dp_cmd  s_cmd;
    t_dp_stat s_stat;
    logic     s_in_ready;

    // controller
    tsdrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (s_in_ready),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    assign i_in.ready = s_in_ready;

    // datapath
    tsdrs_dp #(
        .MEAN_FRAC_BITS (MEAN_FRAC_BITS),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (s_cmd),
        .o_stat          (s_stat),
        .i_item_cmd      (i_in.cmd),
        .i_sample_ok     (i_in.sample_ok),
        .i_first_temp    (i_in.first_temp),
        .i_second_temp   (i_in.second_temp),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_status        (o_out.status),
        .o_channel       (o_out.channel),
        .o_latest_value  (o_out.latest_value),
        .o_minimum_value (o_out.minimum_value),
        .o_maximum_value (o_out.maximum_value),
        .o_mean_value    (o_out.mean_value),
        .o_reading_total (o_out.reading_total),
        .o_fault_total   (o_out.fault_total),
        .o_last          (o_out.last)
    );

endmodule

@@ hw/rtl/tsdrs_div.sv @@
// ----------------------------------------------------------------------------
// tsdrs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsdrs_div import tsdrs_pkg::*; #(
    parameter int DIVIDEND_W = VALUE_W + MEAN_FRAC_BITS_DEF + 1,
    parameter int DIVISOR_W  = COUNT_WIDTH_DEF + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output logic                  o_busy,
    output logic                  o_done
);

    localparam int                CNT_W     = $clog2(DIVIDEND_W + 1);
    localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic [DIVIDEND_W-1:0] r_quot;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_divisor;
    logic [CNT_W-1:0]      r_count;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0]    w_shifted;
    logic [DIVISOR_W+1:0]  w_trial;
    logic                  w_borrow;

    // shift in the next dividend bit and try a subtract
    assign w_shifted = {r_rem, r_quot[DIVIDEND_W-1]};
    assign w_trial   = {1'b0, w_shifted} - {2'b00, r_divisor};
    assign w_borrow  = w_trial[DIVISOR_W+1];

    // iteration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + 1'b1;
                if (r_count == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIVIDEND_W-2:0], ~w_borrow};
            if (w_borrow) begin
                r_rem <= w_shifted[DIVISOR_W-1:0];
            end else begin
                r_rem <= w_trial[DIVISOR_W-1:0];
            end
        end
    end

    assign o_quotient = r_quot;
    assign o_busy     = r_busy;
    assign o_done     = r_done;

endmodule

@@ hw/rtl/tsdrs_dp.sv @@
// ----------------------------------------------------------------------------
// tsdrs_dp
// Datapath: per-channel statistics, counters, mean update and output register.
// ----------------------------------------------------------------------------
`include "two_sensor_delta_running_stats_assert.svh"

module tsdrs_dp import tsdrs_pkg::*; #(
    parameter int MEAN_FRAC_BITS = MEAN_FRAC_BITS_DEF,
    parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  t_dp_cmd                                 i_cmd,
    output t_dp_stat                                o_stat,
    input  logic                                    i_item_cmd,
    input  logic                                    i_sample_ok,
    input  logic signed [TEMP_W-1:0]                i_first_temp,
    input  logic signed [TEMP_W-1:0]                i_second_temp,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [STATUS_W-1:0]                     o_status,
    output logic [CHANNEL_W-1:0]                    o_channel,
    output logic signed [VALUE_W-1:0]               o_latest_value,
    output logic signed [VALUE_W-1:0]               o_minimum_value,
    output logic signed [VALUE_W-1:0]               o_maximum_value,
    output logic signed [VALUE_W+MEAN_FRAC_BITS-1:0] o_mean_value,
    output logic [COUNT_WIDTH-1:0]                  o_reading_total,
    output logic [COUNT_WIDTH-1:0]                  o_fault_total,
    output logic                                    o_last
);

    localparam int MEAN_W = VALUE_W + MEAN_FRAC_BITS;
    localparam int DIFF_W = MEAN_W + 1;
    localparam int DIVR_W = COUNT_WIDTH + 1;

    // captured item
    logic                     r_is_clear;
    logic                     r_is_ok;
    logic signed [TEMP_W-1:0] r_first;
    logic signed [TEMP_W-1:0] r_second;

    // statistics state
    logic signed [VALUE_W-1:0] r_latest [NUM_CHANNELS];
    logic signed [VALUE_W-1:0] r_min    [NUM_CHANNELS];
    logic signed [VALUE_W-1:0] r_max    [NUM_CHANNELS];
    logic signed [MEAN_W-1:0]  r_mean   [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]    r_reading;
    logic [COUNT_WIDTH-1:0]    r_fault;
    logic                      r_neg;

    // output register
    logic                      r_out_valid;
    logic [STATUS_W-1:0]       r_out_status;
    logic [CHANNEL_W-1:0]      r_out_channel;
    logic signed [VALUE_W-1:0] r_out_latest;
    logic signed [VALUE_W-1:0] r_out_min;
    logic signed [VALUE_W-1:0] r_out_max;
    logic signed [MEAN_W-1:0]  r_out_mean;
    logic [COUNT_WIDTH-1:0]    r_out_reading;
    logic [COUNT_WIDTH-1:0]    r_out_fault;
    logic                      r_out_last;

    logic signed [VALUE_W-1:0] w_first;
    logic signed [VALUE_W-1:0] w_second;
    logic signed [VALUE_W-1:0] w_delta;
    logic signed [VALUE_W-1:0] w_value;
    logic signed [DIFF_W-1:0]  w_value_ext;
    logic signed [DIFF_W-1:0]  w_scaled;
    logic signed [DIFF_W-1:0]  w_mean_ext;
    logic signed [DIFF_W-1:0]  w_diff;
    logic [DIFF_W-1:0]         w_mag;
    logic [DIVR_W-1:0]         w_divisor;
    logic [DIFF_W-1:0]         w_quot;
    logic signed [DIFF_W-1:0]  w_step;
    logic signed [DIFF_W-1:0]  w_mean_sum;
    logic                      w_div_busy;
    logic                      w_div_done;
    logic                      w_out_free;

    // channel values from the captured samples
    assign w_first  = {r_first[TEMP_W-1], r_first};
    assign w_second = {r_second[TEMP_W-1], r_second};
    assign w_delta  = (w_first >= w_second) ? (w_first - w_second) : (w_second - w_first);

    always_comb begin
        case (i_cmd.ch)
            CH_FIRST:  w_value = w_first;
            CH_SECOND: w_value = w_second;
            default:   w_value = w_delta;
        endcase
    end

    // mean correction dividend: scaled value minus current mean, as sign and magnitude
    assign w_value_ext = {{(DIFF_W - VALUE_W){w_value[VALUE_W-1]}}, w_value};
    assign w_scaled    = w_value_ext <<< MEAN_FRAC_BITS;
    assign w_mean_ext  = {r_mean[i_cmd.ch][MEAN_W-1], r_mean[i_cmd.ch]};
    assign w_diff      = w_scaled - w_mean_ext;
    assign w_mag       = w_diff[DIFF_W-1] ? -w_diff : w_diff;
    assign w_divisor   = {1'b0, r_reading} + 1'b1;

    tsdrs_div #(
        .DIVIDEND_W (DIFF_W),
        .DIVISOR_W  (DIVR_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_mag),
        .i_divisor  (w_divisor),
        .o_quotient (w_quot),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done)
    );

    // signed quotient truncated toward zero, added to the mean
    assign w_step     = r_neg ? -w_quot : w_quot;
    assign w_mean_sum = w_mean_ext + w_step;

    // captured item and sign of the running division
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_is_clear <= i_item_cmd;
            r_is_ok    <= i_sample_ok;
            r_first    <= i_first_temp;
            r_second   <= i_second_temp;
        end
        if (i_cmd.div_start) begin
            r_neg <= w_diff[DIFF_W-1];
        end
    end

    // statistics and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_latest[c] <= '0;
                r_min[c]    <= '0;
                r_max[c]    <= '0;
                r_mean[c]   <= '0;
            end
            r_reading <= '0;
            r_fault   <= '0;
        end else begin
            if (i_cmd.update) begin
                r_latest[i_cmd.ch] <= w_value;
                r_mean[i_cmd.ch]   <= w_mean_sum[MEAN_W-1:0];
                // first reading since clear seeds min and max
                if (r_reading == '0) begin
                    r_min[i_cmd.ch] <= w_value;
                    r_max[i_cmd.ch] <= w_value;
                end else begin
                    if (w_value < r_min[i_cmd.ch]) begin
                        r_min[i_cmd.ch] <= w_value;
                    end
                    if (w_value > r_max[i_cmd.ch]) begin
                        r_max[i_cmd.ch] <= w_value;
                    end
                end
            end
            if (i_cmd.count_inc && (r_reading != '1)) begin
                r_reading <= r_reading + 1'b1;
            end
            if (i_cmd.fault_inc && (r_fault != '1)) begin
                r_fault <= r_fault + 1'b1;
            end
        end
    end

    // output register, freed when the current item is taken
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status  <= i_cmd.status;
            r_out_channel <= i_cmd.ch;
            r_out_latest  <= r_latest[i_cmd.ch];
            r_out_min     <= r_min[i_cmd.ch];
            r_out_max     <= r_max[i_cmd.ch];
            r_out_mean    <= r_mean[i_cmd.ch];
            r_out_reading <= r_reading;
            r_out_fault   <= r_fault;
            r_out_last    <= i_cmd.last;
        end
    end

    // status toward the controller
    assign o_stat.is_clear = r_is_clear;
    assign o_stat.is_ok    = r_is_ok;
    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = w_out_free;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_channel       = r_out_channel;
    assign o_latest_value  = r_out_latest;
    assign o_minimum_value = r_out_min;
    assign o_maximum_value = r_out_max;
    assign o_mean_value    = r_out_mean;
    assign o_reading_total = r_out_reading;
    assign o_fault_total   = r_out_fault;
    assign o_last          = r_out_last;

    // checks
    `TSDRS_ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, i_cmd.load_out, w_out_free, "output overwritten")
    `TSDRS_ASSERT_IMPL(a_start_when_idle, i_clk, i_rst_n, i_cmd.div_start, !w_div_busy, "divider restarted while busy")
    `TSDRS_ASSERT_NEXT(a_min_le_max, i_clk, i_rst_n, i_cmd.update, r_min[$past(i_cmd.ch)] <= r_max[$past(i_cmd.ch)], "minimum above maximum")

endmodule

@@ hw/rtl/tsdrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsdrs_ctrl
// Controller: sequences capture, per-channel mean division and result items.
// ----------------------------------------------------------------------------
module tsdrs_ctrl import tsdrs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIV_START,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

    t_state   r_state;
    t_state   n_state;
    t_channel r_ch;
    t_channel n_ch;
    t_status  r_status;
    t_status  n_status;

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_ch     = r_ch;
        n_status = r_status;

        o_cmd           = '0;
        o_cmd.ch        = r_ch;
        o_cmd.status    = r_status;
        o_cmd.last      = (r_status != ST_UPDATED) || (r_ch == CH_DELTA);

        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_ch = CH_FIRST;
                if (i_stat.is_clear) begin
                    o_cmd.clear = 1'b1;
                    n_status    = ST_CLEARED;
                    n_state     = S_EMIT;
                end else if (!i_stat.is_ok) begin
                    o_cmd.fault_inc = 1'b1;
                    n_status        = ST_FAULT;
                    n_state         = S_EMIT;
                end else begin
                    n_status = ST_UPDATED;
                    n_state  = S_DIV_START;
                end
            end
            S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.update = 1'b1;
                    if (r_ch == CH_DELTA) begin
                        o_cmd.count_inc = 1'b1;
                        n_ch            = CH_FIRST;
                        n_state         = S_EMIT;
                    end else begin
                        n_ch    = t_channel'(r_ch + 1'b1);
                        n_state = S_DIV_START;
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (o_cmd.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ch = t_channel'(r_ch + 1'b1);
                    end
                end
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ch     <= CH_FIRST;
            r_status <= ST_UPDATED;
        end else begin
            r_state  <= n_state;
            r_ch     <= n_ch;
            r_status <= n_status;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
